>>> rtl/core/b64d_pkg.sv
// Package for the Base64 stream decoder: payload structs, status codes,
// alphabet lookup and skip-character test. No dependencies.
`default_nettype none

package b64d_pkg;

    localparam int CharW    = 8;
    localparam int SextW    = 6;
    localparam int NumSkip  = 4;
    localparam int CfgAddrW = 2;

    localparam logic [CharW-1:0] PadChar = 8'h3D;   // '='
    localparam logic [1:0]       LastPos = 2'd3;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_PAD     = 2'd1,
        ST_INVALID = 2'd2,
        ST_END     = 2'd3
    } status_t;

    typedef enum logic [CfgAddrW-1:0] {
        REG_SKIP_A = 2'd0,
        REG_SKIP_B = 2'd1,
        REG_SKIP_C = 2'd2,
        REG_SKIP_D = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [CharW-1:0] in_char;
        logic             end_of_text;
    } in_item_t;

    typedef struct packed {
        logic [CharW-1:0] out_byte;
        status_t          status;
        logic             last_of_run;
    } out_item_t;

    typedef logic [NumSkip-1:0][CharW-1:0] skip_set_t;

    typedef struct packed {
        logic             is_sym;
        logic             is_pad;
        logic [SextW-1:0] value;
    } sym_t;

    // Group position and drop flag
    typedef struct packed {
        logic [1:0] pos;
        logic       err;
    } ctrl_t;

    // Held sextets of the current group; only the third can be padding
    typedef struct packed {
        logic [SextW-1:0] h0;
        logic [SextW-1:0] h1;
        logic [SextW-1:0] h2;
        logic             h2_pad;
    } held_t;

    // Results of one input item: count 0..3, bytes in data[0..count-1]
    typedef struct packed {
        logic [1:0]                  count;
        status_t                     status;
        logic [2:0][CharW-1:0]       data;
    } burst_t;

    function automatic sym_t sym_decode(input logic [CharW-1:0] c);
        sym_t s;
        s = '0;
        if (c inside {[8'h41:8'h5A]}) begin          // A..Z
            s.is_sym = 1'b1;
            s.value  = SextW'(c - 8'h41);
        end
        else if (c inside {[8'h61:8'h7A]}) begin     // a..z
            s.is_sym = 1'b1;
            s.value  = SextW'(c - 8'h47);
        end
        else if (c inside {[8'h30:8'h39]}) begin     // 0..9
            s.is_sym = 1'b1;
            s.value  = SextW'(c + 8'h04);
        end
        else if (c == 8'h2B) begin                   // +
            s.is_sym = 1'b1;
            s.value  = 6'd62;
        end
        else if (c == 8'h2F) begin                   // /
            s.is_sym = 1'b1;
            s.value  = 6'd63;
        end
        else if (c == PadChar) begin
            s.is_pad = 1'b1;
        end
        return s;
    endfunction

    function automatic logic is_skip(input logic [CharW-1:0] c, input skip_set_t skip);
        logic hit;
        hit = (c == '0);
        for (int i = 0; i < NumSkip; i++) begin
            hit = hit | (c == skip[i]);
        end
        return hit;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/b64d_decode.sv
// Per-character decode step: alphabet lookup, group tracking, error checks.
// Purely combinational; depends on b64d_pkg.
`default_nettype none

module b64d_decode (
    input  b64d_pkg::in_item_t  item,
    input  b64d_pkg::skip_set_t skip,
    input  b64d_pkg::ctrl_t     ctrl,
    input  b64d_pkg::held_t     held,
    output b64d_pkg::ctrl_t     ctrl_upd,
    output b64d_pkg::held_t     held_upd,
    output b64d_pkg::burst_t    burst
);
    import b64d_pkg::*;

    sym_t    sym;
    logic    fail;
    status_t fail_code;

    assign sym = sym_decode(item.in_char);

    always_comb
    begin
        ctrl_upd  = ctrl;
        held_upd  = held;
        burst     = '0;
        fail      = 1'b0;
        fail_code = ST_OK;

        if (ctrl.err) begin
            // dropping until end of string
            if (item.end_of_text) begin
                ctrl_upd.err = 1'b0;
                ctrl_upd.pos = '0;
            end
        end
        else if (!sym.is_sym && !sym.is_pad) begin
            if (!is_skip(item.in_char, skip)) begin
                fail      = 1'b1;
                fail_code = ST_INVALID;
            end
            else if (item.end_of_text) begin
                fail      = 1'b1;
                fail_code = ST_END;
            end
        end
        else if (sym.is_pad && ctrl.pos < 2'd2) begin
            fail      = 1'b1;
            fail_code = ST_PAD;
        end
        else if (ctrl.pos == LastPos && held.h2_pad && !sym.is_pad) begin
            fail      = 1'b1;
            fail_code = ST_PAD;
        end
        else if (ctrl.pos != LastPos) begin
            case (ctrl.pos)
                2'd0:    held_upd.h0 = sym.value;
                2'd1:    held_upd.h1 = sym.value;
                default:
                begin
                    held_upd.h2     = sym.value;
                    held_upd.h2_pad = sym.is_pad;
                end
            endcase
            ctrl_upd.pos = ctrl.pos + 2'd1;
            if (item.end_of_text) begin
                fail      = 1'b1;
                fail_code = ST_END;
            end
        end
        else begin
            // group complete
            burst.data[0] = {held.h0, held.h1[5:4]};
            burst.data[1] = {held.h1[3:0], held.h2[5:2]};
            burst.data[2] = {held.h2[1:0], sym.value};
            burst.count   = held.h2_pad ? 2'd1 : (sym.is_pad ? 2'd2 : 2'd3);
            ctrl_upd.pos  = '0;
        end

        if (fail) begin
            burst.count  = 2'd1;
            burst.status = fail_code;
            burst.data   = '0;
            if (item.end_of_text) begin
                ctrl_upd.err = 1'b0;
                ctrl_upd.pos = '0;
            end
            else begin
                ctrl_upd.err = 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/b64d_burst.sv
// Result register and serialiser: holds one item's results and hands them
// out one transfer at a time. Depends on b64d_pkg.
`default_nettype none

module b64d_burst (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 load,
    input  b64d_pkg::burst_t    burst,
    output logic                can_load,
    output logic                out_valid,
    input  wire                 out_ready,
    output b64d_pkg::out_item_t out_data
);
    import b64d_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg, idx_next;
    burst_t     burst_reg;
    logic       is_last;
    logic       done;

    assign is_last  = (idx_reg == burst_reg.count - 2'd1);
    assign done     = valid_reg && out_ready && is_last;
    assign can_load = !valid_reg || done;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = '0;
        end
        else if (done) begin
            valid_next = 1'b0;
        end
        else if (valid_reg && out_ready) begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end
        else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            burst_reg <= burst;
        end
    end

    always_comb
    begin
        case (idx_reg)
            2'd0:    out_data.out_byte = burst_reg.data[0];
            2'd1:    out_data.out_byte = burst_reg.data[1];
            default: out_data.out_byte = burst_reg.data[2];
        endcase
        out_data.status      = burst_reg.status;
        out_data.last_of_run = is_last;
    end

    assign out_valid = valid_reg;

endmodule

`default_nettype wire

>>> rtl/core/base64_stream_decoder.sv
// Base64 stream decoder (standard alphabet, '=' padding), one character per transfer.
// Path: an input item passes through the input register stage, then the result register.
// Throughput: one character per cycle while the result register is free; an item yielding
// n results (n <= 3) hands them out one at a time through the single result port.
// Reset: rst_n asynchronous, active low; clears group position, drop flag,
// skip registers and both handshake stages. Depends on b64d_pkg, b64d_decode, b64d_burst.
`default_nettype none

module base64_stream_decoder (
    input  wire                              clk,
    input  wire                              rst_n,
    // character input
    input  wire                              in_valid,
    output logic                             in_ready,
    input  b64d_pkg::in_item_t               in_data,
    // decoded results
    output logic                             out_valid,
    input  wire                              out_ready,
    output b64d_pkg::out_item_t              out_data,
    // skip-character registers
    input  wire                              cfg_we,
    input  wire [b64d_pkg::CfgAddrW-1:0]     cfg_addr,
    input  wire [b64d_pkg::CharW-1:0]        cfg_wdata
);
    import b64d_pkg::*;

    // Input register stage
    logic      in_valid_reg, in_valid_next;
    in_item_t  in_data_reg;

    // Decoder state: control part is reset, held sextets are not
    ctrl_t     ctrl_reg, ctrl_next, ctrl_upd;
    held_t     held_reg, held_next, held_upd;

    skip_set_t skip_reg, skip_next;

    burst_t    burst;
    logic      can_load;
    logic      advance;
    logic      load;

    // The held item moves on when it yields nothing, or when the result
    // register is free or drains this cycle.
    assign advance  = in_valid_reg && ((burst.count == 2'd0) || can_load);
    assign load     = advance && (burst.count != 2'd0);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        if (in_valid && in_ready) begin
            in_valid_next = 1'b1;
        end
        else if (advance) begin
            in_valid_next = 1'b0;
        end
        else begin
            in_valid_next = in_valid_reg;
        end
    end

    assign ctrl_next = advance ? ctrl_upd : ctrl_reg;
    assign held_next = advance ? held_upd : held_reg;

    // Register writes; the user must make these happen only while the block is idle (not enforced)
    always_comb
    begin
        skip_next = skip_reg;
        if (cfg_we) begin
            case (cfg_reg_t'(cfg_addr))
                REG_SKIP_A: skip_next[0] = cfg_wdata;
                REG_SKIP_B: skip_next[1] = cfg_wdata;
                REG_SKIP_C: skip_next[2] = cfg_wdata;
                REG_SKIP_D: skip_next[3] = cfg_wdata;
                default:    skip_next    = skip_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
            ctrl_reg     <= '0;
            skip_reg     <= '0;
        end
        else begin
            in_valid_reg <= in_valid_next;
            ctrl_reg     <= ctrl_next;
            skip_reg     <= skip_next;
        end
    end

    // Payload and held sextets: no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            in_data_reg <= in_data;
        end
        held_reg <= held_next;
    end

    b64d_decode u_decode (
        .item     (in_data_reg),
        .skip     (skip_reg),
        .ctrl     (ctrl_reg),
        .held     (held_reg),
        .ctrl_upd (ctrl_upd),
        .held_upd (held_upd),
        .burst    (burst)
    );

    b64d_burst u_burst (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (load),
        .burst     (burst),
        .can_load  (can_load),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

>>> rtl/core/b64d_checker.sv
// Port-level checks for the Base64 stream decoder, bound to the top level.
// Depends on b64d_pkg and base64_stream_decoder.
`default_nettype none

module b64d_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 out_valid,
    input wire                 out_ready,
    input b64d_pkg::out_item_t out_data
);
    import b64d_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // nothing offered straight after reset
    a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("result offered right after reset");

    // error results stand alone and carry a zero byte
    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |->
            out_data.last_of_run && out_data.out_byte == '0)
        else $error("malformed error result");

    // a run continues after a non-final transfer
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_of_run |=> out_valid)
        else $error("run of results broken");

endmodule

bind base64_stream_decoder b64d_checker u_b64d_checker (.*);

`default_nettype wire
